// File: rtl/core/pmfb_pkg.sv
// Shared constants for the paged monochrome framebuffer.
// Item kind codes and panel command bytes; no dependencies.
package pmfb_pkg;

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;

    localparam int          CMD_BYTES       = 3;
    localparam logic [7:0]  CMD_PAGE        = 8'hB0;
    localparam logic [7:0]  CMD_COL_HI      = 8'h10;
    localparam logic [7:0]  NIBBLE_MASK     = 8'h0F;
    localparam logic [7:0]  START_COL_RESET = 8'd30;

endpackage

// File: rtl/core/paged_mono_framebuffer_refresh_top.sv
// Paged monochrome framebuffer: frame store, pixel read-modify-write, refresh stream.
// Depends on pmfb_pkg for kind codes and command constants.
//
// A pixel item is written to the store from ST_MODIFY, in the cycle after its transfer; a
//   refresh item waits in ST_SEND and loads its byte into the output register once the
//   byte ahead of it has left the output register or is leaving it.
// No new item is taken until the last is through: the store read at transfer is followed
//   by its write-back or output load; off-screen pixels and kind 3 stay in ST_IDLE.
// Reset and clear items run a clearing pass over all SCREEN_WIDTH*pages entries (816 by
//   default), one store entry per cycle, with s_tready low; config writes still land.
module paged_mono_framebuffer_refresh_top
    import pmfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 102,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: start_column
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] pos_x, [15:8] pos_y, [16] pixel_on, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // refresh stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast    // frame_end
);

    localparam int NUM_PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = SCREEN_WIDTH * NUM_PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int POS_W      = $clog2(SCREEN_WIDTH + CMD_BYTES);

    localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(SCREEN_WIDTH + CMD_BYTES - 1);
    localparam logic [POS_W-1:0]  CMD_POS   = POS_W'(CMD_BYTES);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SEND
    } state_t;

    state_t state_reg;

    // frame store, one byte per column of a page
    logic [7:0] mem [STORE_SIZE];
    logic [7:0] rd_data_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] addr_reg;      // entry under read-modify-write
    logic [7:0]        mask_reg;
    logic              pix_on_reg;

    logic [7:0]        start_col_reg;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // pending refresh byte, waits in ST_SEND for the output register
    logic [7:0] cmd_byte_reg;
    logic       is_data_reg;
    logic       end_reg;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    // input decode
    logic [7:0]        pos_x, pos_y;
    logic              pixel_on;
    logic              accept;
    logic              pix_valid;
    logic [7:0]        row;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] ref_addr;
    logic              ref_is_cmd;
    logic              frame_last;
    logic [7:0]        cmd_byte;

    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [7:0]        mem_wdata;

    assign pos_x    = s_tdata[7:0];
    assign pos_y    = s_tdata[15:8];
    assign pixel_on = s_tdata[16];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // on screen: non-negative and below the screen size
    assign pix_valid = !pos_x[7] && ({1'b0, pos_x[6:0]} < 8'(SCREEN_WIDTH)) &&
                       !pos_y[7] && ({1'b0, pos_y[6:0]} < 8'(SCREEN_HEIGHT));

    // rows arrive counted from the bottom
    assign row      = 8'(SCREEN_HEIGHT - 1) - pos_y;
    assign pix_addr = ADDR_W'(row[7:3]) * WIDTH_A + ADDR_W'(pos_x[6:0]);

    assign ref_addr   = ADDR_W'(page_reg) * WIDTH_A + ADDR_W'(pos_reg - CMD_POS);
    assign ref_is_cmd = (pos_reg < CMD_POS);
    assign frame_last = (pos_reg == LAST_POS) && (page_reg == LAST_PAGE);

    always_comb begin
        case (pos_reg)
            POS_W'(0): cmd_byte = CMD_PAGE | 8'(page_reg);
            POS_W'(1): cmd_byte = CMD_COL_HI | ((start_col_reg >> 4) & NIBBLE_MASK);
            default:   cmd_byte = start_col_reg & NIBBLE_MASK;
        endcase
    end

    // refresh position advance, wraps at the end of a page and of the frame
    always_comb begin
        page_next = page_reg;
        pos_next  = pos_reg + POS_W'(1);
        if (pos_reg == LAST_POS) begin
            pos_next  = '0;
            page_next = (page_reg == LAST_PAGE) ? '0 : page_reg + PAGE_W'(1);
        end
    end

    // store port control: one read at transfer, one write for clear or write-back
    assign mem_re    = accept;
    assign mem_raddr = (s_tuser == KIND_REFRESH) ? ref_addr : pix_addr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = pix_on_reg ? (rd_data_reg | mask_reg) : (rd_data_reg & ~mask_reg);
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_MODIFY: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_col_reg <= START_COL_RESET;
        end else if (cfg_wr_en) begin
            start_col_reg <= cfg_wr_data;
        end
    end

    // control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            page_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output register empties on a transfer; ST_SEND handles its own reload
            if (m_tready && state_reg != ST_SEND) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (s_tuser)
                            KIND_PIXEL: begin
                                addr_reg   <= pix_addr;
                                mask_reg   <= 8'(1) << row[2:0];
                                pix_on_reg <= pixel_on;
                                if (pix_valid) begin
                                    state_reg <= ST_MODIFY;
                                end
                            end
                            KIND_CLEAR: begin
                                clr_addr_reg <= '0;
                                state_reg    <= ST_CLEAR;
                            end
                            KIND_REFRESH: begin
                                cmd_byte_reg <= cmd_byte;
                                is_data_reg  <= !ref_is_cmd;
                                end_reg      <= frame_last;
                                page_reg     <= page_next;
                                pos_reg      <= pos_next;
                                state_reg    <= ST_SEND;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MODIFY: begin
                    state_reg <= ST_IDLE;
                end
                ST_SEND: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= is_data_reg ? rd_data_reg : cmd_byte_reg;
                        m_tuser_reg  <= is_data_reg;
                        m_tlast_reg  <= end_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a waiting result is never overwritten by the pending byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND && m_tvalid_reg && !m_tready) |=> (state_reg == ST_SEND))
        else $error("pending refresh byte dropped while output stalled");

    // frame end is only flagged on a data byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tlast_reg || m_tuser_reg))
        else $error("frame end on a command byte");

    // the store is never written while a new item reads it
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("store write collides with item read");

    // refresh counters stay within a page and the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg <= LAST_POS) && (page_reg <= LAST_PAGE))
        else $error("refresh position out of range");

endmodule
